FILE: src/multilevel_fifo_queue_assert.svh
// Assertion macros for the multilevel FIFO queue.
// They compile to nothing when SYNTHESIS is defined.
`ifndef MULTILEVEL_FIFO_QUEUE_ASSERT_SVH
`define MULTILEVEL_FIFO_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// The condition must hold in the same cycle as the trigger.
`define MFQ_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("multilevel_fifo_queue: assertion failed");

// The condition must hold in the cycle after the trigger.
`define MFQ_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("multilevel_fifo_queue: assertion failed");

`else

`define MFQ_ASSERT_NOW(lbl, pre, post)
`define MFQ_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

FILE: src/mfq_pkg.sv
package mfq_pkg;

   // Queue geometry.
   localparam int MAX_LEVELS  = 8;
   localparam int LEVEL_DEPTH = 16;
   localparam int ITEM_WIDTH  = 32;

   // Fixed field widths of the interface.
   localparam int CMD_W    = 1;
   localparam int LEVEL_W  = 3;
   localparam int TAG_W    = 32;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 4;

   // Derived widths.
   localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int PTR_W  = $clog2(LEVEL_DEPTH);
   localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
   localparam int ADDR_W = $clog2(MAX_LEVELS * LEVEL_DEPTH);
   localparam int DEPTH  = MAX_LEVELS * LEVEL_DEPTH;
   // Width used to compare levels against the active level count.
   localparam int CMP_W  = 8;

   localparam logic [CSR_W-1:0] LEVELS_RESET = CSR_W'(8);

   // Operation codes.
   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 1'b0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 1'b1;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic {
      ST_IDLE,
      ST_LOAD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic exec;
      logic load_out;
   } cmd_type;

endpackage

FILE: src/multilevel_fifo_queue.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   req_cmd, req_level, req_item_in
// rsp_      out        rsp_valid/rsp_stall   rsp_status, rsp_item_out, rsp_found_level
// csr_      in         csr_valid/csr_ready   csr_data (levels_in_use)
//
// In each transaction the level search, pointer update and tag memory access
// happen in the accept cycle; the registered memory read data then moves into
// the output register from the load state.
// A result stalled at the output holds back the load of the next transaction,
// and with it the accept of the one after that.
// Reset is synchronous: it empties every level and sets levels_in_use to 8.
`include "multilevel_fifo_queue_assert.svh"

module multilevel_fifo_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mfq_pkg::CMD_W-1:0]     req_cmd,
   input  logic [mfq_pkg::LEVEL_W-1:0]   req_level,
   input  logic [mfq_pkg::TAG_W-1:0]     req_item_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mfq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [mfq_pkg::TAG_W-1:0]     rsp_item_out,
   output logic [mfq_pkg::LEVEL_W-1:0]   rsp_found_level,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mfq_pkg::CSR_W-1:0]     csr_data
);

   mfq_pkg::cmd_type cmd;
   logic             rsp_failed;

   // The register accepts a write in any cycle.
   assign csr_ready = 1'b1;

   mfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   mfq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_cmd         (req_cmd),
      .req_level       (req_level),
      .req_item_in     (req_item_in),
      .csr_write       (csr_valid && csr_ready),
      .csr_data        (csr_data),
      .rsp_status      (rsp_status),
      .rsp_item_out    (rsp_item_out),
      .rsp_found_level (rsp_found_level)
   );

   // A presented result that reports a failure.
   assign rsp_failed = rsp_valid && (rsp_status != mfq_pkg::STAT_OK);

   // An accepted transaction blocks the next one while its read completes.
   `MFQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // A new result never overwrites one that is still stalled.
   `MFQ_ASSERT_NOW(a_no_overwrite, cmd.load_out, !(rsp_valid && rsp_stall))
   // A result appears only through a load of the output register.
   `MFQ_ASSERT_NOW(a_valid_from_load, $rose(rsp_valid), $past(cmd.load_out))
   // Failed transactions carry a zero tag and level.
   `MFQ_ASSERT_NOW(a_fail_zero, rsp_failed, rsp_item_out == '0 && rsp_found_level == '0)

endmodule

FILE: src/mfq_ctrl.sv
module mfq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mfq_pkg::cmd_type cmd
);

   mfq_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // The output register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mfq_pkg::ST_IDLE: begin
            if (req_valid) state_in = mfq_pkg::ST_LOAD;
         end
         mfq_pkg::ST_LOAD: begin
            if (out_free) state_in = mfq_pkg::ST_IDLE;
         end
         default: state_in = mfq_pkg::ST_IDLE;
      endcase
   end

   // Outputs and commands.
   always_comb begin
      req_stall    = 1'b1;
      cmd.exec     = 1'b0;
      cmd.load_out = 1'b0;
      case (state_ff)
         mfq_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.exec  = req_valid;
         end
         mfq_pkg::ST_LOAD: begin
            cmd.load_out = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // The result stays valid until it is taken without a stall.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/mfq_datapath.sv
module mfq_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  mfq_pkg::cmd_type              cmd,
   input  logic [mfq_pkg::CMD_W-1:0]     req_cmd,
   input  logic [mfq_pkg::LEVEL_W-1:0]   req_level,
   input  logic [mfq_pkg::TAG_W-1:0]     req_item_in,
   input  logic                          csr_write,
   input  logic [mfq_pkg::CSR_W-1:0]     csr_data,
   output logic [mfq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [mfq_pkg::TAG_W-1:0]     rsp_item_out,
   output logic [mfq_pkg::LEVEL_W-1:0]   rsp_found_level
);

   // Configuration and per-level FIFO bookkeeping.
   logic [mfq_pkg::CSR_W-1:0]      levels_ff;
   logic [mfq_pkg::PTR_W-1:0]      head_ff  [mfq_pkg::MAX_LEVELS];
   logic [mfq_pkg::PTR_W-1:0]      tail_ff  [mfq_pkg::MAX_LEVELS];
   logic [mfq_pkg::CNT_W-1:0]      count_ff [mfq_pkg::MAX_LEVELS];
   logic [mfq_pkg::PTR_W-1:0]      head_in  [mfq_pkg::MAX_LEVELS];
   logic [mfq_pkg::PTR_W-1:0]      tail_in  [mfq_pkg::MAX_LEVELS];
   logic [mfq_pkg::CNT_W-1:0]      count_in [mfq_pkg::MAX_LEVELS];

   // Tag storage, one region of LEVEL_DEPTH entries per level.
   logic [mfq_pkg::ITEM_WIDTH-1:0] mem [mfq_pkg::DEPTH];
   logic [mfq_pkg::ITEM_WIDTH-1:0] rdata_ff;

   // Result of the executed transaction, waiting for the read data.
   mfq_pkg::status_type            stat_ff, stat_in;
   logic [mfq_pkg::LVL_W-1:0]      found_ff;
   logic                           deq_ok_ff;

   // Output register.
   logic [mfq_pkg::STATUS_W-1:0]   out_status_ff;
   logic [mfq_pkg::TAG_W-1:0]      out_item_ff;
   logic [mfq_pkg::LEVEL_W-1:0]    out_level_ff;

   logic [mfq_pkg::CMP_W-1:0]      active_n;
   logic [mfq_pkg::CMP_W-1:0]      level_ext;
   logic [mfq_pkg::LVL_W-1:0]      lvl_idx;
   logic                           in_range;
   logic [mfq_pkg::MAX_LEVELS-1:0] nonempty;
   logic [mfq_pkg::MAX_LEVELS-1:0] full;
   logic                           hi_hit, lo_hit, hit;
   logic [mfq_pkg::LVL_W-1:0]      hi_idx, lo_idx, found_idx;
   logic                           do_enq, do_deq;
   logic [mfq_pkg::PTR_W-1:0]      tail_sel, head_sel;
   logic [mfq_pkg::ADDR_W-1:0]     wr_addr, rd_addr;

   // Active level count, clamped to the number of levels built.
   always_comb begin
      active_n = mfq_pkg::CMP_W'(levels_ff);
      if (active_n > mfq_pkg::CMP_W'(mfq_pkg::MAX_LEVELS)) begin
         active_n = mfq_pkg::CMP_W'(mfq_pkg::MAX_LEVELS);
      end
      level_ext = mfq_pkg::CMP_W'(req_level);
      lvl_idx   = mfq_pkg::LVL_W'(level_ext);
      in_range  = level_ext < active_n;
   end

   // Per-level flags; only active levels take part in the search.
   always_comb begin
      for (int i = 0; i < mfq_pkg::MAX_LEVELS; i++) begin
         nonempty[i] = (count_ff[i] != '0) && (mfq_pkg::CMP_W'(i) < active_n);
         full[i]     = count_ff[i] == mfq_pkg::CNT_W'(mfq_pkg::LEVEL_DEPTH);
      end
   end

   // Rotating search: the first non-empty level at or above the start,
   // otherwise the first non-empty level from zero.
   always_comb begin
      hi_hit = 1'b0;
      lo_hit = 1'b0;
      hi_idx = '0;
      lo_idx = '0;
      for (int i = mfq_pkg::MAX_LEVELS - 1; i >= 0; i--) begin
         if (nonempty[i]) begin
            lo_hit = 1'b1;
            lo_idx = mfq_pkg::LVL_W'(i);
            if (mfq_pkg::CMP_W'(i) >= level_ext) begin
               hi_hit = 1'b1;
               hi_idx = mfq_pkg::LVL_W'(i);
            end
         end
      end
      hit       = hi_hit || lo_hit;
      found_idx = hi_hit ? hi_idx : lo_idx;
   end

   // Decide the outcome of the transaction.
   always_comb begin
      do_enq  = 1'b0;
      do_deq  = 1'b0;
      stat_in = mfq_pkg::STAT_OK;
      if (!in_range) begin
         stat_in = mfq_pkg::STAT_RANGE;
      end else if (req_cmd == mfq_pkg::CMD_ENQUEUE) begin
         if (full[lvl_idx]) stat_in = mfq_pkg::STAT_FULL;
         else do_enq = cmd.exec;
      end else begin
         if (!hit) stat_in = mfq_pkg::STAT_EMPTY;
         else do_deq = cmd.exec;
      end
      tail_sel = tail_ff[lvl_idx];
      head_sel = head_ff[found_idx];
      wr_addr  = mfq_pkg::ADDR_W'(mfq_pkg::ADDR_W'(lvl_idx) *
                 mfq_pkg::ADDR_W'(mfq_pkg::LEVEL_DEPTH) + mfq_pkg::ADDR_W'(tail_sel));
      rd_addr  = mfq_pkg::ADDR_W'(mfq_pkg::ADDR_W'(found_idx) *
                 mfq_pkg::ADDR_W'(mfq_pkg::LEVEL_DEPTH) + mfq_pkg::ADDR_W'(head_sel));
   end

   // Pointer and count updates, one lane per level.
   always_comb begin
      for (int i = 0; i < mfq_pkg::MAX_LEVELS; i++) begin
         head_in[i]  = head_ff[i];
         tail_in[i]  = tail_ff[i];
         count_in[i] = count_ff[i];
         if (do_enq && lvl_idx == mfq_pkg::LVL_W'(i)) begin
            tail_in[i]  = (tail_ff[i] == mfq_pkg::PTR_W'(mfq_pkg::LEVEL_DEPTH - 1)) ?
                          '0 : tail_ff[i] + mfq_pkg::PTR_W'(1);
            count_in[i] = count_ff[i] + mfq_pkg::CNT_W'(1);
         end
         if (do_deq && found_idx == mfq_pkg::LVL_W'(i)) begin
            head_in[i]  = (head_ff[i] == mfq_pkg::PTR_W'(mfq_pkg::LEVEL_DEPTH - 1)) ?
                          '0 : head_ff[i] + mfq_pkg::PTR_W'(1);
            count_in[i] = count_ff[i] - mfq_pkg::CNT_W'(1);
         end
      end
   end

   // Control state: configuration register, pointers and counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= mfq_pkg::LEVELS_RESET;
         for (int i = 0; i < mfq_pkg::MAX_LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         if (csr_write) levels_ff <= csr_data;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Tag memory with a registered read port.
   always_ff @(posedge clock) begin
      if (do_enq) mem[wr_addr] <= mfq_pkg::ITEM_WIDTH'(req_item_in);
      if (do_deq) rdata_ff <= mem[rd_addr];
   end

   // Capture the outcome, then move it to the output register.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         stat_ff   <= stat_in;
         found_ff  <= found_idx;
         deq_ok_ff <= do_deq;
      end
      if (cmd.load_out) begin
         out_status_ff <= stat_ff;
         out_item_ff   <= deq_ok_ff ? mfq_pkg::TAG_W'(rdata_ff) : '0;
         out_level_ff  <= deq_ok_ff ? mfq_pkg::LEVEL_W'(found_ff) : '0;
      end
   end

   assign rsp_status      = out_status_ff;
   assign rsp_item_out    = out_item_ff;
   assign rsp_found_level = out_level_ff;

endmodule
